/* sv/mdc_pkg.sv */
`default_nettype none

package mdc_pkg;

	// default grid size
	localparam int GRID_ROWS_DEF = 16;
	localparam int GRID_COLS_DEF = 16;

	// direction codes
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// request kinds
	localparam logic REQ_RESTART = 1'b0;
	localparam logic REQ_STEP    = 1'b1;

	// input item
	typedef struct packed {
		logic       req_type;
		logic [7:0] rand_value;
	} mdc_req_t;

	// result item
	typedef struct packed {
		logic [3:0] cell_row;
		logic [3:0] cell_col;
		logic [1:0] direction;
		logic       carved;
		logic       backtracked;
		logic       done_res;
	} mdc_res_t;

	// datapath operations driven by the control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_IDLE,
		OP_CLR,
		OP_RESTART,
		OP_PROBE,
		OP_PICK,
		OP_CARVE,
		OP_POP,
		OP_LOAD,
		OP_DONE
	} mdc_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_START,
		C_CLR_MORE,
		C_IS_STEP,
		C_FINISHED,
		C_NONE_FREE,
		C_STACK_EMPTY
	} mdc_cond_t;

	typedef logic [3:0] mdc_upc_t;

	// control word
	typedef struct packed {
		mdc_op_t    op;
		mdc_cond_t  cond;
		mdc_upc_t   target;
		logic       rd_en;
		logic [1:0] rd_dir;
		logic       cap_en;
		logic [1:0] cap_dir;
	} mdc_ctrl_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic clr_last;
		logic is_step;
		logic finished;
		logic none_free;
		logic stack_empty;
	} mdc_flags_t;

	// program addresses
	localparam mdc_upc_t UA_BOOT     = 4'd0;
	localparam mdc_upc_t UA_IDLE     = 4'd1;
	localparam mdc_upc_t UA_DISPATCH = 4'd2;
	localparam mdc_upc_t UA_CLEAR    = 4'd3;
	localparam mdc_upc_t UA_MARK     = 4'd4;
	localparam mdc_upc_t UA_CHECK    = 4'd5;
	localparam mdc_upc_t UA_PRB_R    = 4'd6;
	localparam mdc_upc_t UA_PRB_D    = 4'd7;
	localparam mdc_upc_t UA_PRB_L    = 4'd8;
	localparam mdc_upc_t UA_PRB_END  = 4'd9;
	localparam mdc_upc_t UA_PICK     = 4'd10;
	localparam mdc_upc_t UA_CARVE    = 4'd11;
	localparam mdc_upc_t UA_BACK     = 4'd12;
	localparam mdc_upc_t UA_LOAD     = 4'd13;
	localparam mdc_upc_t UA_DONE     = 4'd14;

	function automatic mdc_ctrl_t mdc_word(input mdc_op_t op, input mdc_cond_t cond,
			input mdc_upc_t target, input logic rd_en, input logic [1:0] rd_dir,
			input logic cap_en, input logic [1:0] cap_dir);
		mdc_ctrl_t w;
		w.op      = op;
		w.cond    = cond;
		w.target  = target;
		w.rd_en   = rd_en;
		w.rd_dir  = rd_dir;
		w.cap_en  = cap_en;
		w.cap_dir = cap_dir;
		return w;
	endfunction

	// control program
	function automatic mdc_ctrl_t mdc_ucode(input mdc_upc_t a);
		mdc_ctrl_t w;
		unique case (a)
			UA_BOOT:     w = mdc_word(OP_CLR, C_CLR_MORE, UA_BOOT, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_IDLE:     w = mdc_word(OP_IDLE, C_NO_START, UA_IDLE, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_DISPATCH: w = mdc_word(OP_NOP, C_IS_STEP, UA_CHECK, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_CLEAR:    w = mdc_word(OP_CLR, C_CLR_MORE, UA_CLEAR, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_MARK:     w = mdc_word(OP_RESTART, C_ALWAYS, UA_IDLE, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_CHECK:    w = mdc_word(OP_PROBE, C_FINISHED, UA_DONE, 1'b1, DIR_UP,
					1'b0, DIR_UP);
			UA_PRB_R:    w = mdc_word(OP_PROBE, C_ALWAYS, UA_PRB_D, 1'b1, DIR_RIGHT,
					1'b1, DIR_UP);
			UA_PRB_D:    w = mdc_word(OP_PROBE, C_ALWAYS, UA_PRB_L, 1'b1, DIR_DOWN,
					1'b1, DIR_RIGHT);
			UA_PRB_L:    w = mdc_word(OP_PROBE, C_ALWAYS, UA_PRB_END, 1'b1, DIR_LEFT,
					1'b1, DIR_DOWN);
			UA_PRB_END:  w = mdc_word(OP_PROBE, C_ALWAYS, UA_PICK, 1'b0, DIR_UP,
					1'b1, DIR_LEFT);
			UA_PICK:     w = mdc_word(OP_PICK, C_NONE_FREE, UA_BACK, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_CARVE:    w = mdc_word(OP_CARVE, C_ALWAYS, UA_IDLE, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_BACK:     w = mdc_word(OP_POP, C_STACK_EMPTY, UA_DONE, 1'b0, DIR_UP,
					1'b0, DIR_UP);
			UA_LOAD:     w = mdc_word(OP_LOAD, C_ALWAYS, UA_IDLE, 1'b0, DIR_UP, 1'b0, DIR_UP);
			UA_DONE:     w = mdc_word(OP_DONE, C_ALWAYS, UA_IDLE, 1'b0, DIR_UP, 1'b0, DIR_UP);
			default:     w = mdc_word(OP_NOP, C_ALWAYS, UA_IDLE, 1'b0, DIR_UP, 1'b0, DIR_UP);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* sv/mdc_seq.sv */
`default_nettype none

module mdc_seq
	import mdc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire mdc_flags_t flags,
	output mdc_ctrl_t       ctrl,
	output logic            busy
);

	mdc_upc_t upc_q;
	logic     take;

	// control word fetch
	assign ctrl = mdc_ucode(upc_q);
	assign busy = (upc_q != UA_IDLE);

	// jump condition
	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:      take = 1'b1;
			C_NO_START:    take = !start;
			C_CLR_MORE:    take = !flags.clr_last;
			C_IS_STEP:     take = flags.is_step;
			C_FINISHED:    take = flags.finished;
			C_NONE_FREE:   take = flags.none_free;
			C_STACK_EMPTY: take = flags.stack_empty;
			default:       take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_BOOT;
		end else if (take) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + 4'd1;
		end
	end

`ifndef SYNTHESIS
	a_boot_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UA_BOOT && flags.clr_last) |=> (upc_q == UA_IDLE))
		else $error("clearing pass after reset did not end in idle");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UA_IDLE && !start) |=> (upc_q == UA_IDLE))
		else $error("sequencer left idle without a transfer");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UA_IDLE && start) |=> (upc_q == UA_DISPATCH))
		else $error("accepted transfer not dispatched");
`endif

endmodule

`default_nettype wire

/* sv/mdc_datapath.sv */
`default_nettype none

module mdc_datapath
	import mdc_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire mdc_req_t  req,
	input  wire mdc_ctrl_t ctrl,
	output mdc_flags_t     flags,
	output mdc_res_t       res,
	output logic           res_valid
);

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int LW    = $clog2(CELLS + 1);

	typedef struct packed {
		logic          ok;
		logic [RW-1:0] r;
		logic [CW-1:0] c;
	} nbr_t;

	// walker and stack state
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [LW-1:0] level_q;
	logic          finished_q;
	logic [AW-1:0] clr_q;
	logic          res_valid_q;

	// payload registers
	mdc_req_t         req_q;
	logic [3:0]       free_q;
	logic [1:0]       dir_q;
	mdc_res_t         res_q;
	logic             vis_rd_q;
	logic [RW+CW-1:0] stk_rd_q;

	// memories
	logic             visited_mem [CELLS];
	logic [RW+CW-1:0] stack_mem   [CELLS];

	logic          accept;
	logic          full;
	logic          clr_last;
	logic [LW-1:0] level_m1;
	nbr_t          nbr_rd;
	nbr_t          nbr_cap;
	nbr_t          nbr_mv;
	logic          vis_we;
	logic [AW-1:0] vis_wa;
	logic          vis_wd;
	logic [2:0]    free_cnt;
	logic [1:0]    pick_idx;
	logic [1:0]    pick_dir;
	logic [RW+3:0] row_ext;
	logic [CW+3:0] col_ext;
	logic [RW+3:0] stk_row_ext;
	logic [CW+3:0] stk_col_ext;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
			input logic [CW-1:0] c);
		return AW'(r) * AW'(GRID_COLS) + AW'(c);
	endfunction

	// neighbor of the walker in one direction
	function automatic nbr_t nbr_of(input logic [1:0] d, input logic [RW-1:0] r,
			input logic [CW-1:0] c);
		nbr_t n;
		n.r  = r;
		n.c  = c;
		n.ok = 1'b0;
		unique case (d)
			DIR_UP: begin
				n.ok = (r != '0);
				n.r  = r - RW'(1);
			end
			DIR_RIGHT: begin
				n.ok = (c != CW'(GRID_COLS - 1));
				n.c  = c + CW'(1);
			end
			DIR_DOWN: begin
				n.ok = (r != RW'(GRID_ROWS - 1));
				n.r  = r + RW'(1);
			end
			DIR_LEFT: begin
				n.ok = (c != '0);
				n.c  = c - CW'(1);
			end
			default: n.ok = 1'b0;
		endcase
		return n;
	endfunction

	// value mod 3 from the sum of base-4 digits
	function automatic logic [1:0] mod3(input logic [7:0] v);
		logic [3:0] s;
		logic [1:0] m;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		unique case (s) inside
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
			4'd2, 4'd5, 4'd8, 4'd11:       m = 2'd2;
			default:                       m = 2'd0;
		endcase
		return m;
	endfunction

	assign accept   = (ctrl.op == OP_IDLE) && start;
	assign full     = (level_q == LW'(CELLS));
	assign clr_last = (clr_q == AW'(CELLS - 1));
	assign level_m1 = level_q - LW'(1);
	assign nbr_rd   = nbr_of(ctrl.rd_dir, row_q, col_q);
	assign nbr_cap  = nbr_of(ctrl.cap_dir, row_q, col_q);
	assign nbr_mv   = nbr_of(dir_q, row_q, col_q);

	assign flags.clr_last    = clr_last;
	assign flags.is_step     = (req_q.req_type == REQ_STEP);
	assign flags.finished    = finished_q;
	assign flags.none_free   = (free_q == 4'd0);
	assign flags.stack_empty = (level_q == '0);

	// low four bits of positions
	assign row_ext     = {4'b0000, row_q};
	assign col_ext     = {4'b0000, col_q};
	assign stk_row_ext = {4'b0000, stk_rd_q[RW+CW-1:CW]};
	assign stk_col_ext = {4'b0000, stk_rd_q[CW-1:0]};

	// random pick among the free directions
	always_comb begin
		logic [2:0] k;
		free_cnt = 3'($countones(free_q));
		unique case (free_cnt)
			3'd2:    pick_idx = {1'b0, req_q.rand_value[0]};
			3'd3:    pick_idx = mod3(req_q.rand_value);
			3'd4:    pick_idx = req_q.rand_value[1:0];
			default: pick_idx = 2'd0;
		endcase
		k        = 3'd0;
		pick_dir = DIR_UP;
		for (int d = 0; d < 4; d++) begin
			if (free_q[d]) begin
				if (k == {1'b0, pick_idx}) begin
					pick_dir = 2'(d);
				end
				k = k + 3'd1;
			end
		end
	end

	// visited map write port
	always_comb begin
		vis_we = 1'b0;
		vis_wa = clr_q;
		vis_wd = 1'b0;
		unique case (ctrl.op)
			OP_CLR: begin
				vis_we = 1'b1;
				vis_wa = clr_q;
				vis_wd = 1'b0;
			end
			OP_RESTART: begin
				vis_we = 1'b1;
				vis_wa = '0;
				vis_wd = 1'b1;
			end
			OP_CARVE: begin
				vis_we = 1'b1;
				vis_wa = cell_addr(nbr_mv.r, nbr_mv.c);
				vis_wd = 1'b1;
			end
			default: vis_we = 1'b0;
		endcase
	end

	// visited map
	always_ff @(posedge clk) begin
		if (vis_we) begin
			visited_mem[vis_wa] <= vis_wd;
		end
		if (ctrl.rd_en) begin
			vis_rd_q <= visited_mem[cell_addr(nbr_rd.r, nbr_rd.c)];
		end
	end

	// path stack
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_CARVE) begin
			stack_mem[level_q[AW-1:0]] <= {row_q, col_q};
		end
		if (ctrl.op == OP_POP) begin
			stk_rd_q <= stack_mem[level_m1[AW-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			level_q     <= '0;
			finished_q  <= 1'b0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (ctrl.op)
				OP_CLR: begin
					clr_q <= clr_last ? '0 : clr_q + AW'(1);
				end
				OP_RESTART: begin
					row_q       <= '0;
					col_q       <= '0;
					level_q     <= '0;
					finished_q  <= 1'b0;
					res_valid_q <= 1'b1;
				end
				OP_CARVE: begin
					row_q       <= nbr_mv.r;
					col_q       <= nbr_mv.c;
					level_q     <= level_q + LW'(1);
					res_valid_q <= 1'b1;
				end
				OP_POP: begin
					if (level_q != '0) begin
						level_q <= level_m1;
					end
				end
				OP_LOAD: begin
					row_q       <= stk_rd_q[RW+CW-1:CW];
					col_q       <= stk_rd_q[CW-1:0];
					res_valid_q <= 1'b1;
				end
				OP_DONE: begin
					finished_q  <= 1'b1;
					res_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// input capture, probe results, picked direction and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (ctrl.cap_en) begin
			free_q[ctrl.cap_dir] <= nbr_cap.ok && !vis_rd_q && !full;
		end
		if (ctrl.op == OP_PICK) begin
			dir_q <= pick_dir;
		end
		unique case (ctrl.op)
			OP_RESTART: begin
				res_q <= '0;
			end
			OP_CARVE: begin
				res_q.cell_row    <= row_ext[3:0];
				res_q.cell_col    <= col_ext[3:0];
				res_q.direction   <= dir_q;
				res_q.carved      <= 1'b1;
				res_q.backtracked <= 1'b0;
				res_q.done_res    <= 1'b0;
			end
			OP_LOAD: begin
				res_q.cell_row    <= stk_row_ext[3:0];
				res_q.cell_col    <= stk_col_ext[3:0];
				res_q.direction   <= DIR_UP;
				res_q.carved      <= 1'b0;
				res_q.backtracked <= 1'b1;
				res_q.done_res    <= 1'b0;
			end
			OP_DONE: begin
				res_q.cell_row    <= row_ext[3:0];
				res_q.cell_col    <= col_ext[3:0];
				res_q.direction   <= DIR_UP;
				res_q.carved      <= 1'b0;
				res_q.backtracked <= 1'b0;
				res_q.done_res    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ($countones({res_q.carved, res_q.backtracked, res_q.done_res}) <= 1))
		else $error("result flags more than one outcome");

	a_carve_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_CARVE) |-> (level_q < LW'(CELLS) && free_q != 4'd0))
		else $error("carve with full stack or no free neighbor");

	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_RESTART) |=> (res_valid_q && level_q == '0 && !finished_q))
		else $error("restart left stale walker state");

	a_load_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_LOAD) |-> ($past(ctrl.op) == OP_POP))
		else $error("stack read data used without a pop");
`endif

endmodule

`default_nettype wire

/* sv/maze_dfs_carver.sv */
// channel  | ports                       | transfer
// ---------+-----------------------------+------------------------------------
// request  | start, busy, req            | rising edge with start high, busy low
// result   | res_valid, res              | the one cycle res_valid is high
//
// A restart sweeps the visited map one cell a cycle, then marks the start cell.
// The same sweep runs after reset with busy high. A step reads the four neighbor
// visited bits through the map's single read port, one a cycle, then carves to a
// picked free neighbor or pops to backtrack; a finished maze repeats its done.
// busy is low again in the cycle the result is shown, so the next request may
// transfer then. Results cannot be held off by the receiver.
`default_nettype none

module maze_dfs_carver
	import mdc_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire mdc_req_t req,
	output logic          res_valid,
	output mdc_res_t      res
);

	mdc_ctrl_t  ctrl;
	mdc_flags_t flags;

	// program sequencer
	mdc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// walker, map and stack
	mdc_datapath #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.ctrl      (ctrl),
		.flags     (flags),
		.res       (res),
		.res_valid (res_valid)
	);

endmodule

`default_nettype wire
